>>> sv/mpp_pkg.sv
// shared types, constants and float compare for the padded strided max pool
package mpp_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_KERNEL = 3'd0;
    localparam logic [2:0] REG_PAD    = 3'd1;
    localparam logic [2:0] REG_STEP   = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;

    // reset values of the configuration registers
    localparam logic [3:0]  KERNEL_RST = 4'd2;
    localparam logic [2:0]  PAD_RST    = 3'd0;
    localparam logic [3:0]  STEP_RST   = 4'd2;
    localparam logic [12:0] HEIGHT_RST = 13'd1;
    localparam logic [8:0]  WIDTH_RST  = 9'd1;

    localparam int unsigned DEF_MAX_WIDTH  = 256;
    localparam int unsigned DEF_MAX_KERNEL = 8;
    localparam logic [12:0] HEIGHT_CAP     = 13'd4096;

    localparam logic [31:0] NEG_INF = 32'hFF80_0000;

    // window index tracker: t is the signed offset, q = t / s and m = t % s once t >= 0
    typedef struct packed {
        logic signed [13:0] t;
        logic [12:0]        q;
        logic [3:0]         m;
    } cnt_t;

    // one result word waiting for its run_last mark
    typedef struct packed {
        logic [31:0] value;
        logic [12:0] row;
        logic [8:0]  col;
        logic        pdone;
    } res_t;

    // advance a tracker by one
    function automatic cnt_t cnt_step(input cnt_t c, input logic [3:0] s);
        cnt_t n;
        n = c;
        n.t = c.t + 14'sd1;
        if (n.t == 14'sd0)
        begin
            n.q = '0;
            n.m = '0;
        end
        else if (!c.t[13])
        begin
            if (c.m + 4'd1 == s)
            begin
                n.m = '0;
                n.q = c.q + 13'd1;
            end
            else
            begin
                n.m = c.m + 4'd1;
            end
        end
        return n;
    endfunction

    // ieee single less-than, false when either side is nan
    function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic res;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        if (a_nan || b_nan)
            res = 1'b0;
        else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            res = 1'b0;
        else if (a[31] && !b[31])
            res = 1'b1;
        else if (!a[31] && b[31])
            res = 1'b0;
        else if (!a[31])
            res = a[30:0] < b[30:0];
        else
            res = a[30:0] > b[30:0];
        return res;
    endfunction

endpackage

>>> sv/mpp_ram.sv
// generic single write port ram with registered read
module mpp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

>>> sv/mpp_div.sv
// serial restoring divider, one quotient bit per cycle
module mpp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [12:0] num,
    input  logic [3:0]  den,
    output logic        done,
    output logic [12:0] quo
);

    logic [12:0] quo_reg, quo_next;
    logic [4:0]  rem_reg, rem_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [4:0]  rem_sh;

    // one shift-subtract step
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[3:0], quo_reg[12]};
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (rem_sh >= {1'b0, den})
            begin
                rem_next = rem_sh - {1'b0, den};
                quo_next = {quo_reg[11:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[11:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd12)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> sv/max_pool_2d_padded_strided.sv
// top level of the streaming padded strided 2-d max pool
// Pixels are float words in raster order, one per input handshake; each pixel is worked
// through by a sequencer that walks every window row and column offset of the kernel in
// turn and updates the covered windows in a line store one at a time through a single
// read-compare-write path, and stalls when the output is not taken. After reset and after
// every write to one of the five configuration registers, the output size is worked out by
// a serial divider, during which no pixel is taken.
module max_pool_2d_padded_strided
    import mpp_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_KERNEL = DEF_MAX_KERNEL
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] pixel_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] max_value,
    output logic [12:0] out_row,
    output logic [8:0]  out_col,
    output logic        run_last,
    output logic        plane_done
);

    localparam int unsigned ROW_SPAN = MAX_WIDTH + MAX_KERNEL;
    localparam int unsigned KB       = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int unsigned WB       = $clog2(ROW_SPAN);
    localparam int unsigned DEPTH    = (1 << KB) * (1 << WB);
    localparam int unsigned CPW      = $clog2(MAX_WIDTH);
    localparam logic [3:0]  KCAP     = (MAX_KERNEL > 15) ? 4'd15 : 4'(MAX_KERNEL);
    localparam logic [12:0] WCAP     = 13'(MAX_WIDTH);
    localparam logic [12:0] SPAN_LIM = 13'(ROW_SPAN);

    typedef enum logic [6:0] {
        S_CALC_H = 7'b0000001,
        S_CALC_W = 7'b0000010,
        S_IDLE   = 7'b0000100,
        S_ROW    = 7'b0001000,
        S_COL    = 7'b0010000,
        S_UPD    = 7'b0100000,
        S_FLUSH  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]  kernel_reg, kernel_next;
    logic [2:0]  pad_reg, pad_next;
    logic [3:0]  step_reg, step_next;
    logic [12:0] height_reg, height_next;
    logic [8:0]  width_reg, width_next;

    logic signed [14:0] out_h_reg, out_h_next;
    logic signed [14:0] out_w_reg, out_w_next;
    logic               calc_start_reg, calc_start_next;

    logic [11:0]    r_reg, r_next;
    logic [CPW-1:0] c_reg, c_next;
    cnt_t           rcnt_reg, rcnt_next;
    cnt_t           ccnt_reg, ccnt_next;

    cnt_t        icnt_reg, icnt_next;
    cnt_t        jcnt_reg, jcnt_next;
    logic [3:0]  ikh_reg, ikh_next;
    logic [3:0]  jkw_reg, jkw_next;
    logic [12:0] h_reg, h_next;
    logic        first_r_reg, first_r_next;
    logic        last_r_reg, last_r_next;
    logic        first_c_reg, first_c_next;
    logic        last_c_reg, last_c_next;
    logic [8:0]  w_reg, w_next;
    logic [12:0] wq_reg, wq_next;
    logic [31:0] x_reg, x_next;
    logic [KB+WB-1:0] addr_reg, addr_next;

    res_t hold_reg, hold_next;
    logic hold_v_reg, hold_v_next;
    res_t out_reg, out_next;
    logic out_last_reg, out_last_next;
    logic out_v_reg, out_v_next;

    // effective configuration
    logic [3:0]         k_eff, km1;
    logic [2:0]         p_eff;
    logic [3:0]         s_eff;
    logic [12:0]        h_eff, w_eff;
    logic signed [14:0] num_h, num_w, num_sel;
    logic [12:0]        num_mag;
    logic signed [13:0] cnt_t0;
    cnt_t               cnt_init;

    // divider hookup
    logic        div_start, div_done;
    logic [12:0] div_quo;
    logic signed [14:0] div_res;

    // store hookup
    logic        ram_we, ram_re;
    logic [KB+WB-1:0] ram_raddr;
    logic [31:0] ram_rdata;
    logic [31:0] cur_base, cur_new;
    logic        emit, can_push, out_free;
    logic        row_ok, col_ok;

    always_comb
    begin
        k_eff = (kernel_reg == 4'd0) ? 4'd1 : ((kernel_reg > KCAP) ? KCAP : kernel_reg);
        km1   = k_eff - 4'd1;
        p_eff = ({1'b0, pad_reg} > km1) ? km1[2:0] : pad_reg;
        s_eff = (step_reg == 4'd0) ? 4'd1 : step_reg;
        h_eff = (height_reg == 13'd0) ? 13'd1
              : ((height_reg > HEIGHT_CAP) ? HEIGHT_CAP : height_reg);
        w_eff = (width_reg == 9'd0) ? 13'd1
              : (({4'd0, width_reg} > WCAP) ? WCAP : {4'd0, width_reg});
        num_h = $signed({2'b00, h_eff}) + $signed({11'd0, p_eff, 1'b0})
              - $signed({11'd0, k_eff});
        num_w = $signed({2'b00, w_eff}) + $signed({11'd0, p_eff, 1'b0})
              - $signed({11'd0, k_eff});
        cnt_t0 = $signed({11'd0, p_eff}) - $signed({10'd0, k_eff}) + 14'sd1;
        cnt_init.t = cnt_t0;
        cnt_init.q = '0;
        cnt_init.m = '0;
    end

    // numerator magnitude and signed result for the output size divide
    always_comb
    begin
        num_sel = state_reg[1] ? num_w : num_h;
        num_mag = num_sel[14] ? 13'(-num_sel) : num_sel[12:0];
        div_res = num_sel[14] ? (15'sd1 - $signed({2'b00, div_quo}))
                              : ($signed({2'b00, div_quo}) + 15'sd1);
    end

    assign div_start = calc_start_reg && (state_reg == S_CALC_H || state_reg == S_CALC_W);

    mpp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_mag),
        .den   (s_eff),
        .done  (div_done),
        .quo   (div_quo)
    );

    mpp_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (cur_new),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // window update datapath
    always_comb
    begin
        cur_base = (first_r_reg && first_c_reg) ? NEG_INF : ram_rdata;
        cur_new  = flt_lt(cur_base, x_reg) ? x_reg : cur_base;
        emit     = last_r_reg && last_c_reg;
        out_free = !out_v_reg || out_ready;
        can_push = !(emit && hold_v_reg) || out_free;
        row_ok   = !icnt_reg.t[13] && (icnt_reg.m == 4'd0)
                && ($signed({2'b00, icnt_reg.q}) < out_h_reg);
        col_ok   = !jcnt_reg.t[13] && (jcnt_reg.m == 4'd0)
                && ($signed({2'b00, jcnt_reg.q}) < out_w_reg)
                && (jcnt_reg.q < SPAN_LIM);
        ram_raddr = {h_reg[KB-1:0], jcnt_reg.q[WB-1:0]};
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        kernel_next     = kernel_reg;
        pad_next        = pad_reg;
        step_next       = step_reg;
        height_next     = height_reg;
        width_next      = width_reg;
        out_h_next      = out_h_reg;
        out_w_next      = out_w_reg;
        calc_start_next = 1'b0;
        r_next          = r_reg;
        c_next          = c_reg;
        rcnt_next       = rcnt_reg;
        ccnt_next       = ccnt_reg;
        icnt_next       = icnt_reg;
        jcnt_next       = jcnt_reg;
        ikh_next        = ikh_reg;
        jkw_next        = jkw_reg;
        h_next          = h_reg;
        first_r_next    = first_r_reg;
        last_r_next     = last_r_reg;
        first_c_next    = first_c_reg;
        last_c_next     = last_c_reg;
        w_next          = w_reg;
        wq_next         = wq_reg;
        x_next          = x_reg;
        addr_next       = addr_reg;
        hold_next       = hold_reg;
        hold_v_next     = hold_v_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_v_next      = out_v_reg && !out_ready;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        unique case (state_reg)
            S_CALC_H:
            begin
                if (!calc_start_reg && div_done)
                begin
                    out_h_next      = div_res;
                    calc_start_next = 1'b1;
                    state_next      = S_CALC_W;
                end
            end
            S_CALC_W:
            begin
                if (!calc_start_reg && div_done)
                begin
                    out_w_next = div_res;
                    rcnt_next  = cnt_init;
                    ccnt_next  = cnt_init;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = pixel_value;
                    icnt_next  = rcnt_reg;
                    ikh_next   = km1;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                if (row_ok)
                begin
                    h_next       = icnt_reg.q;
                    first_r_next = (ikh_reg == 4'd0) || (r_reg == 12'd0);
                    last_r_next  = (ikh_reg == km1) || ({1'b0, r_reg} == h_eff - 13'd1);
                    jcnt_next    = ccnt_reg;
                    jkw_next     = km1;
                    state_next   = S_COL;
                end
                else if (ikh_reg == 4'd0)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    ikh_next  = ikh_reg - 4'd1;
                    icnt_next = cnt_step(icnt_reg, s_eff);
                end
            end
            S_COL:
            begin
                if (col_ok)
                begin
                    ram_re       = 1'b1;
                    addr_next    = ram_raddr;
                    wq_next      = jcnt_reg.q;
                    w_next       = jcnt_reg.q[8:0];
                    first_c_next = (jkw_reg == 4'd0) || (c_reg == '0);
                    last_c_next  = (jkw_reg == km1)
                                || ({{(13-CPW){1'b0}}, c_reg} == w_eff - 13'd1);
                    state_next   = S_UPD;
                end
                else if (jkw_reg != 4'd0)
                begin
                    jkw_next  = jkw_reg - 4'd1;
                    jcnt_next = cnt_step(jcnt_reg, s_eff);
                end
                else if (ikh_reg == 4'd0)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    ikh_next   = ikh_reg - 4'd1;
                    icnt_next  = cnt_step(icnt_reg, s_eff);
                    state_next = S_ROW;
                end
            end
            S_UPD:
            begin
                if (can_push)
                begin
                    ram_we = 1'b1;
                    if (emit)
                    begin
                        if (hold_v_reg)
                        begin
                            out_next      = hold_reg;
                            out_last_next = 1'b0;
                            out_v_next    = 1'b1;
                        end
                        hold_next.value = cur_new;
                        hold_next.row   = h_reg;
                        hold_next.col   = w_reg;
                        hold_next.pdone = ($signed({2'b00, h_reg}) == out_h_reg - 15'sd1)
                                       && ($signed({2'b00, wq_reg}) == out_w_reg - 15'sd1);
                        hold_v_next     = 1'b1;
                    end
                    // next column offset, next row offset when the columns are done, or flush after the last row
                    if (jkw_reg != 4'd0)
                    begin
                        jkw_next   = jkw_reg - 4'd1;
                        jcnt_next  = cnt_step(jcnt_reg, s_eff);
                        state_next = S_COL;
                    end
                    else if (ikh_reg == 4'd0)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        ikh_next   = ikh_reg - 4'd1;
                        icnt_next  = cnt_step(icnt_reg, s_eff);
                        state_next = S_ROW;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!hold_v_reg || out_free)
                begin
                    if (hold_v_reg)
                    begin
                        out_next      = hold_reg;
                        out_last_next = 1'b1;
                        out_v_next    = 1'b1;
                        hold_v_next   = 1'b0;
                    end
                    // raster position of the next pixel
                    if ({{(13-CPW){1'b0}}, c_reg} == w_eff - 13'd1)
                    begin
                        c_next    = '0;
                        ccnt_next = cnt_init;
                        if ({1'b0, r_reg} == h_eff - 13'd1)
                        begin
                            r_next    = '0;
                            rcnt_next = cnt_init;
                        end
                        else
                        begin
                            r_next    = r_reg + 12'd1;
                            rcnt_next = cnt_step(rcnt_reg, s_eff);
                        end
                    end
                    else
                    begin
                        c_next    = c_reg + {{(CPW-1){1'b0}}, 1'b1};
                        ccnt_next = cnt_step(ccnt_reg, s_eff);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CALC_H;
            end
        endcase

        // writes to a configuration register restart the plane and the size calculation
        if (cfg_we)
        begin
            case (cfg_index)
                REG_KERNEL: kernel_next = cfg_data[3:0];
                REG_PAD:    pad_next    = cfg_data[2:0];
                REG_STEP:   step_next   = cfg_data[3:0];
                REG_HEIGHT: height_next = cfg_data;
                REG_WIDTH:  width_next  = cfg_data[8:0];
                default:    kernel_next = kernel_reg;
            endcase
            if (cfg_index == REG_KERNEL || cfg_index == REG_PAD || cfg_index == REG_STEP
                || cfg_index == REG_HEIGHT || cfg_index == REG_WIDTH)
            begin
                r_next          = '0;
                c_next          = '0;
                calc_start_next = 1'b1;
                state_next      = S_CALC_H;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CALC_H;
            kernel_reg     <= KERNEL_RST;
            pad_reg        <= PAD_RST;
            step_reg       <= STEP_RST;
            height_reg     <= HEIGHT_RST;
            width_reg      <= WIDTH_RST;
            calc_start_reg <= 1'b1;
            out_h_reg      <= '0;
            out_w_reg      <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            rcnt_reg       <= '0;
            ccnt_reg       <= '0;
            hold_v_reg     <= 1'b0;
            out_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kernel_reg     <= kernel_next;
            pad_reg        <= pad_next;
            step_reg       <= step_next;
            height_reg     <= height_next;
            width_reg      <= width_next;
            calc_start_reg <= calc_start_next;
            out_h_reg      <= out_h_next;
            out_w_reg      <= out_w_next;
            r_reg          <= r_next;
            c_reg          <= c_next;
            rcnt_reg       <= rcnt_next;
            ccnt_reg       <= ccnt_next;
            hold_v_reg     <= hold_v_next;
            out_v_reg      <= out_v_next;
        end
    end

    // iteration and payload registers
    always_ff @(posedge clk)
    begin
        icnt_reg     <= icnt_next;
        jcnt_reg     <= jcnt_next;
        ikh_reg      <= ikh_next;
        jkw_reg      <= jkw_next;
        h_reg        <= h_next;
        first_r_reg  <= first_r_next;
        last_r_reg   <= last_r_next;
        first_c_reg  <= first_c_next;
        last_c_reg   <= last_c_next;
        w_reg        <= w_next;
        wq_reg       <= wq_next;
        x_reg        <= x_next;
        addr_reg     <= addr_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_v_reg;
    assign max_value  = out_reg.value;
    assign out_row    = out_reg.row;
    assign out_col    = out_reg.col;
    assign run_last   = out_last_reg;
    assign plane_done = out_reg.pdone;

endmodule

>>> tb/tb_max_pool_2d_padded_strided.sv
// testbench for the streaming padded strided 2-d max pool
`timescale 1ns / 1ps

module tb_max_pool_2d_padded_strided;
    import mpp_pkg::*;

    localparam int LINE_SPAN = 256 + 8;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [31:0] value;
        logic [12:0] row;
        logic [8:0]  col;
        logic        last;
        logic        pdone;
    } pool_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] pixel_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] max_value;
    logic [12:0] out_row;
    logic [8:0]  out_col;
    logic        run_last;
    logic        plane_done;

    // shadow configuration and stream position
    logic [3:0]  sh_kernel;
    logic [2:0]  sh_pad;
    logic [3:0]  sh_step;
    logic [12:0] sh_height;
    logic [8:0]  sh_width;
    int          cur_row;
    int          cur_col;
    logic [31:0] window_max [8*LINE_SPAN];

    pool_word_t  pending_windows [$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          idle_free = 1'b0;

    max_pool_2d_padded_strided dut (.*);

    always #5 clk = ~clk;

    // ieee less-than, nan never compares true
    function automatic bit fp_less(logic [31:0] a, logic [31:0] b);
        bit an;
        bit bn;
        an = a[30:23] == 8'hFF && a[22:0] != 0;
        bn = b[30:23] == 8'hFF && b[22:0] != 0;
        if (an || bn) return 1'b0;
        if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
        if (a[31] != b[31]) return a[31];
        if (!a[31]) return a[30:0] < b[30:0];
        return a[30:0] > b[30:0];
    endfunction

    // fold one pixel into every window covering it, queue finished windows
    task automatic predict_pixel(logic [31:0] x);
        int k, p, s, hh, ww, oh, ow, kh, kw, th, tw, h, w, rs, re, cs, ce, idx, n, first;
        logic [31:0] cur;
        pool_word_t pw;
        k = sh_kernel < 1 ? 1 : (sh_kernel > 8 ? 8 : sh_kernel);
        p = sh_pad > k - 1 ? k - 1 : sh_pad;
        s = sh_step == 0 ? 1 : sh_step;
        hh = sh_height < 1 ? 1 : (sh_height > 4096 ? 4096 : sh_height);
        ww = sh_width < 1 ? 1 : (sh_width > 256 ? 256 : sh_width);
        oh = (hh + 2 * p - k) / s + 1;
        ow = (ww + 2 * p - k) / s + 1;
        n = 0;
        first = pending_windows.size();
        for (kh = k - 1; kh >= 0; kh--)
        begin
            th = cur_row + p - kh;
            if (th < 0 || th % s != 0) continue;
            h = th / s;
            if (h >= oh) continue;
            rs = h * s - p; if (rs < 0) rs = 0;
            re = h * s + k - 1 - p; if (re > hh - 1) re = hh - 1;
            for (kw = k - 1; kw >= 0; kw--)
            begin
                tw = cur_col + p - kw;
                if (tw < 0 || tw % s != 0) continue;
                w = tw / s;
                if (w >= ow || w >= LINE_SPAN) continue;
                cs = w * s - p; if (cs < 0) cs = 0;
                ce = w * s + k - 1 - p; if (ce > ww - 1) ce = ww - 1;
                idx = (h % 8) * LINE_SPAN + w;
                cur = (cur_row == rs && cur_col == cs) ? NEG_INF : window_max[idx];
                if (fp_less(cur, x)) cur = x;
                window_max[idx] = cur;
                if (cur_row == re && cur_col == ce && n < 64)
                begin
                    pw.value = cur;
                    pw.row = h[12:0];
                    pw.col = w[8:0];
                    pw.last = 1'b0;
                    pw.pdone = (h == oh - 1 && w == ow - 1);
                    pending_windows.push_back(pw);
                    n++;
                end
            end
        end
        if (n > 0) pending_windows[first + n - 1].last = 1'b1;
        cur_col++;
        if (cur_col >= ww)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= hh) cur_row = 0;
        end
    endtask

    // random idle decision
    function automatic bit take_gap();
        return !idle_free && $urandom_range(99) < 13;
    endfunction

    // send one pixel word, valid stays up for a following word
    task automatic send_pixel(logic [31:0] x);
        while (take_gap())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_value <= x;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_pixel(x);
        @(negedge clk);
    endtask

    // wait for drain, then allow the block to finish any resultless pixel
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_windows.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // write one register while idle, enable is dropped by the caller
    task automatic write_reg(logic [2:0] index, logic [12:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(negedge clk);
        case (index)
            REG_KERNEL: sh_kernel = data[3:0];
            REG_PAD:    sh_pad = data[2:0];
            REG_STEP:   sh_step = data[3:0];
            REG_HEIGHT: sh_height = data;
            REG_WIDTH:  sh_width = data[8:0];
            default: ;
        endcase
        cur_row = 0;
        cur_col = 0;
    endtask

    task automatic set_geometry(int k, int p, int s, int h, int w);
        wait_drained();
        write_reg(REG_KERNEL, 13'(k));
        write_reg(REG_PAD, 13'(p));
        write_reg(REG_STEP, 13'(s));
        write_reg(REG_HEIGHT, 13'(h));
        write_reg(REG_WIDTH, 13'(w));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_float();
        case ($urandom_range(9))
            0: return 32'h7FC0_0000 | $urandom_range(1, 255);
            1: return $urandom_range(1) ? 32'h7F80_0000 : NEG_INF;
            2: return $urandom_range(1) ? 32'h0000_0000 : 32'h8000_0000;
            3: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_plane(int count);
        repeat (count) send_pixel(rand_float());
    endtask

    // directed extremes and special cases
    task automatic test_directed();
        // reset geometry: 1x1 plane with k 2 gives output size one
        send_pixel(32'h3F80_0000);
        send_pixel(32'hFFFF_FFFF);
        // 2x2 kernel with ties, nan, infinities and signed zeros
        set_geometry(2, 0, 2, 2, 2);
        send_pixel(32'h8000_0000);
        send_pixel(32'h0000_0000);
        send_pixel(32'h7FC0_0000);
        send_pixel(NEG_INF);
        send_pixel(32'h7F80_0000);
        send_pixel(32'h7F80_0000);
        send_pixel(32'hFFC0_0001);
        send_pixel(32'h0000_0000);
        // out of range kernel, stride and oversize pad
        set_geometry(0, 7, 0, 2, 2);
        send_plane(4);
        set_geometry(15, 7, 15, 3, 3);
        send_plane(9);
        // degenerate size yields nothing
        set_geometry(5, 0, 1, 2, 2);
        send_plane(4);
    endtask

    // random geometries, mostly small, a few wide with partial planes
    task automatic test_random();
        int sent;
        int h;
        int w;
        int cnt;
        int reps;
        sent = 0;
        while (sent < 45)
        begin
            h = $urandom_range(1, 6);
            w = ($urandom_range(7) == 0) ? $urandom_range(200, 511) : $urandom_range(1, 9);
            if (w > 256) h = 1;
            set_geometry($urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 15),
                         ($urandom_range(15) == 0) ? 13'h1FFF : h, w);
            cnt = h * (w > 256 ? 256 : w);
            if (cnt > 16) cnt = 16;
            reps = $urandom_range(1, 2);
            repeat (reps) send_plane(cnt);
            sent += reps * cnt;
            if (sent > 15 && sent < 35)
            begin
                idle_free = 1'b1;
                send_plane(cnt);
                idle_free = 1'b0;
                sent += cnt;
            end
        end
    endtask

    // 8x8 worst case kernel with pad, many windows per pixel
    task automatic test_dense();
        set_geometry(8, 7, 1, 8, 8);
        send_plane(64);
        // sender holds off until everything arrives
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_windows.size() != 0) @(negedge clk);
        send_plane(20);
    endtask

    // receiver side: random stall, compare against the oldest window
    always @(negedge clk)
        out_ready <= !take_gap();

    always @(posedge clk)
    begin
        pool_word_t got;
        pool_word_t want;
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            got = {max_value, out_row, out_col, run_last, plane_done};
            if (pending_windows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end
            else
            begin
                want = pending_windows.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("exp %h %0d %0d %b %b got %h %0d %0d %b %b",
                                 want.value, want.row, want.col, want.last, want.pdone,
                                 got.value, got.row, got.col, got.last, got.pdone);
                end
            end
        end
    end

    // timeout
    always @(posedge clk)
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end

    initial
    begin
        sh_kernel = KERNEL_RST;
        sh_pad = PAD_RST;
        sh_step = STEP_RST;
        sh_height = HEIGHT_RST;
        sh_width = WIDTH_RST;
        cur_row = 0;
        cur_col = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random();
        test_dense();
        wait_drained();
        if (mismatches == 0 && pending_windows.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
